FILE: rtl/core/tri3d_pkg.sv
// Shared types and constants of the triangle area pipeline.
package tri3d_pkg;

	localparam int AREA_W = 42;

	typedef logic [AREA_W-1:0] area_t;

endpackage

FILE: rtl/core/tri3d_sqrt.sv
// Pipelined floor square root, one root bit per stage, with saturation to the area width.
module tri3d_sqrt #(
	parameter int SUM_W  = 84,
	parameter int ROOT_W = 42
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [SUM_W-1:0]    sum,
	output logic                out_valid,
	output tri3d_pkg::area_t    root
);
	import tri3d_pkg::*;

	localparam int DW  = SUM_W + 2;
	localparam int RXW = (ROOT_W > AREA_W) ? ROOT_W : AREA_W + 1;

	// Index 0 is the incoming sum; entry j holds the state after stage j.
	logic [SUM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic              vld_s  [ROOT_W+1];

	logic [RXW-1:0]    root_x;
	area_t             area_q;
	logic              done_q;

	assign rem_s[0]  = sum;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_valid;

	for (genvar j = 1; j <= ROOT_W; j++) begin : g_stage
		localparam int B = ROOT_W - j;

		logic [DW-1:0] delta;
		logic [DW-1:0] diff;
		logic          take;

		// (r + 2^B)^2 - r^2 with r holding only bits above B
		assign delta = (DW'(root_s[j-1]) << (B + 1)) | (DW'(1) << (2 * B));
		assign diff  = DW'(rem_s[j-1]) - delta;
		assign take  = ~diff[DW-1];

		always_ff @(posedge clk) begin
			rem_s[j]  <= take ? diff[SUM_W-1:0] : rem_s[j-1];
			root_s[j] <= take ? (root_s[j-1] | (ROOT_W'(1) << B)) : root_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	assign root_x = RXW'(root_s[ROOT_W]);

	// Clamp a root that does not fit the area field.
	always_ff @(posedge clk) begin
		area_q <= (|root_x[RXW-1:AREA_W]) ? '1 : root_x[AREA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[ROOT_W];
		end
	end

	assign out_valid = done_q;
	assign root      = area_q;

endmodule

FILE: rtl/core/triangle_area_3d.sv
// Top level of the 3D triangle area pipeline.
//
// Accepts one triangle (vertices A, B, C, signed fixed point with 10 fraction
// bits) in every clock cycle: busy is always low, so a transaction is taken at
// each edge where start is high. Each transaction produces exactly one result,
// shown on area with done high for a single cycle. The receiver cannot hold
// results off, and none is needed: the pipeline never stalls and results leave
// in acceptance order. Most of the pipeline is the square root, which resolves
// one root bit per register stage; seven arithmetic stages come before it and
// one output register after it. The area is the floor of |AB x AC| taken with
// 20 fraction bits, read as the area with 21 fraction bits; a root that would
// not fit in 42 bits (only possible above a width of 20) saturates to all ones.
module triangle_area_3d #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [COORD_WIDTH-1:0]   ax,
	input  logic [COORD_WIDTH-1:0]   ay,
	input  logic [COORD_WIDTH-1:0]   az,
	input  logic [COORD_WIDTH-1:0]   bx,
	input  logic [COORD_WIDTH-1:0]   by_coord,
	input  logic [COORD_WIDTH-1:0]   bz,
	input  logic [COORD_WIDTH-1:0]   cx,
	input  logic [COORD_WIDTH-1:0]   cy,
	input  logic [COORD_WIDTH-1:0]   cz,
	output logic                     done,
	output tri3d_pkg::area_t         area
);
	import tri3d_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int W1  = W + 1;          // edge vector component
	localparam int PW  = 2 * W + 2;      // signed product and cross component
	localparam int MW  = 2 * W + 1;      // magnitude of a cross component
	localparam int H   = W + 1;          // low half of a magnitude
	localparam int SQW = 2 * MW;         // square of a magnitude
	localparam int SW  = 4 * W + 4;      // sum of three squares
	localparam int RW  = 2 * W + 2;      // root of that sum

	logic                 accept;

	// Stage 1: edge vectors AB and AC.
	logic signed [W1-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic                 v_s1;
	// Stage 2: the six products of the cross product.
	logic signed [PW-1:0] p_s2 [6];
	logic                 v_s2;
	// Stage 3: cross components.
	logic signed [PW-1:0] k_s3 [3];
	logic                 v_s3;
	// Stage 4: their magnitudes.
	logic [PW-1:0]        k_neg [3];
	logic [MW-1:0]        m_s4 [3];
	logic                 v_s4;
	// Stage 5: partial products of each square.
	logic [2*W-1:0]       hh_s5 [3];
	logic [2*W:0]         hl_s5 [3];
	logic [2*H-1:0]       ll_s5 [3];
	logic                 v_s5;
	// Stage 6: squares.
	logic [SQW-1:0]       sq_s6 [3];
	logic                 v_s6;
	// Stage 7: sum of squares.
	logic [SW-1:0]        sum_s7;
	logic                 v_s7;

	// Never stall: a triangle may enter every cycle.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			k_neg[c] = -k_s3[c];
		end
	end

	// Datapath registers: no reset, qualified by the valid bits below.
	always_ff @(posedge clk) begin
		ux_s1 <= {bx[W-1], bx} - {ax[W-1], ax};
		uy_s1 <= {by_coord[W-1], by_coord} - {ay[W-1], ay};
		uz_s1 <= {bz[W-1], bz} - {az[W-1], az};
		vx_s1 <= {cx[W-1], cx} - {ax[W-1], ax};
		vy_s1 <= {cy[W-1], cy} - {ay[W-1], ay};
		vz_s1 <= {cz[W-1], cz} - {az[W-1], az};

		p_s2[0] <= PW'(uy_s1) * PW'(vz_s1);
		p_s2[1] <= PW'(uz_s1) * PW'(vy_s1);
		p_s2[2] <= PW'(uz_s1) * PW'(vx_s1);
		p_s2[3] <= PW'(ux_s1) * PW'(vz_s1);
		p_s2[4] <= PW'(ux_s1) * PW'(vy_s1);
		p_s2[5] <= PW'(uy_s1) * PW'(vx_s1);

		k_s3[0] <= p_s2[0] - p_s2[1];
		k_s3[1] <= p_s2[2] - p_s2[3];
		k_s3[2] <= p_s2[4] - p_s2[5];

		for (int c = 0; c < 3; c++) begin
			// Drop the sign: the square only needs the magnitude.
			m_s4[c]  <= k_s3[c][PW-1] ? k_neg[c][MW-1:0] : k_s3[c][MW-1:0];
			// Split each magnitude into halves to keep multipliers narrow.
			hh_s5[c] <= (2 * W)'(m_s4[c][MW-1:H]) * (2 * W)'(m_s4[c][MW-1:H]);
			hl_s5[c] <= (2 * W + 1)'(m_s4[c][MW-1:H]) * (2 * W + 1)'(m_s4[c][H-1:0]);
			ll_s5[c] <= (2 * H)'(m_s4[c][H-1:0]) * (2 * H)'(m_s4[c][H-1:0]);
			sq_s6[c] <= (SQW'(hh_s5[c]) << (2 * H)) + (SQW'(hl_s5[c]) << (H + 1))
				+ SQW'(ll_s5[c]);
		end

		sum_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
	end

	// Advance the valid bits alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// The root is twice the area; halving is only a change of binary point.
	tri3d_sqrt #(
		.SUM_W  (SW),
		.ROOT_W (RW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.sum       (sum_s7),
		.out_valid (done),
		.root      (area)
	);

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the triangle_area_3d pipeline.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tri3d_pkg::*;

	localparam int COORD_W = 20;
	localparam int C_MIN = -(1 << (COORD_W - 1));
	localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
	// One fixed-point unit (10 fraction bits) and the right triangle it spans.
	localparam int UNIT = 1 << 10;
	localparam area_t UNIT_RIGHT_AREA = area_t'(64'd1048576);
	// Right triangle with both legs spanning the full coordinate range.
	localparam area_t FULL_RIGHT_AREA = area_t'(64'd1099509530625);
	// Pipeline depth of the design from acceptance to done.
	localparam int LATENCY = 2 * COORD_W + 10;
	localparam int DRAIN_CYCLES = LATENCY + 10;
	localparam int WATCHDOG_LIMIT = 10 * LATENCY;
	localparam int RANDOM_TRIANGLES = 700;
	localparam int MAX_GAP = 11;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		coord_t ax, ay, az;
		coord_t bx, by_coord, bz;
		coord_t cx, cy, cz;
	} tri_t;

	typedef struct {
		tri_t  verts;
		bit    known;
		area_t area;
	} area_row_t;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic [COORD_W-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
	logic         done;
	area_t        area;

	// Expected areas of transactions still inside the pipeline, oldest first.
	area_t pending_areas[$];
	// Expectation typed into the directed table for the triangle now on the ports.
	bit    row_known;
	area_t row_area;
	int    failures = 0;
	int    idle_cycles = 0;

	triangle_area_3d #(
		.COORD_WIDTH(COORD_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.ax       (ax),
		.ay       (ay),
		.az       (az),
		.bx       (bx),
		.by_coord (by_coord),
		.bz       (bz),
		.cx       (cx),
		.cy       (cy),
		.cz       (cz),
		.done     (done),
		.area     (area)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor of |AB x AC| with 20 fraction bits, which reads as the area with 21.
	// The products are carried at 128 bits, so the cross product and the sum of
	// squares are exact; a root too wide for the port saturates to all ones.
	function automatic area_t twice_area_root(tri_t t);
		logic signed [COORD_W:0] ux, uy, uz, vx, vy, vz;
		logic signed [127:0]     kx, ky, kz, sum, root, cand;
		int                      b;
		ux = (COORD_W + 1)'(t.bx) - (COORD_W + 1)'(t.ax);
		uy = (COORD_W + 1)'(t.by_coord) - (COORD_W + 1)'(t.ay);
		uz = (COORD_W + 1)'(t.bz) - (COORD_W + 1)'(t.az);
		vx = (COORD_W + 1)'(t.cx) - (COORD_W + 1)'(t.ax);
		vy = (COORD_W + 1)'(t.cy) - (COORD_W + 1)'(t.ay);
		vz = (COORD_W + 1)'(t.cz) - (COORD_W + 1)'(t.az);
		kx = 128'(uy) * 128'(vz) - 128'(uz) * 128'(vy);
		ky = 128'(uz) * 128'(vx) - 128'(ux) * 128'(vz);
		kz = 128'(ux) * 128'(vy) - 128'(uy) * 128'(vx);
		sum = kx * kx + ky * ky + kz * kz;
		if (sum[127:2*AREA_W] != '0)
			return '1;
		root = '0;
		for (b = AREA_W - 1; b >= 0; b--) begin
			cand = root | (128'sd1 <<< b);
			if (cand * cand <= sum)
				root = cand;
		end
		return area_t'(root);
	endfunction

	function automatic tri_t vertices(int a_x, int a_y, int a_z, int b_x, int b_y, int b_z,
			int c_x, int c_y, int c_z);
		tri_t t;
		t.ax = coord_t'(a_x);
		t.ay = coord_t'(a_y);
		t.az = coord_t'(a_z);
		t.bx = coord_t'(b_x);
		t.by_coord = coord_t'(b_y);
		t.bz = coord_t'(b_z);
		t.cx = coord_t'(c_x);
		t.cy = coord_t'(c_y);
		t.cz = coord_t'(c_z);
		return t;
	endfunction

	function automatic int offset_within(int reach);
		return int'($urandom_range(0, 2 * reach)) - reach;
	endfunction

	// Bias towards the corners of the coordinate range.
	function automatic int corner_coord();
		case ($urandom_range(0, 5))
			0: return C_MIN;
			1: return C_MAX;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return int'(coord_t'($urandom));
		endcase
	endfunction

	function automatic tri_t random_triangle();
		int p[9];
		int d[3];
		int k;
		int kind;
		tri_t t;
		kind = $urandom_range(0, 99);
		foreach (p[i])
			p[i] = int'(coord_t'($urandom));
		if (kind < 40) begin
			// full-range vertices
		end else if (kind < 60) begin
			// small triangle around a random A; wrapping near the edges is fine
			for (int i = 3; i < 9; i++)
				p[i] = p[i % 3] + offset_within(1 << $urandom_range(0, 12));
		end else if (kind < 75) begin
			// collinear: B = A + d, C = A + k*d, kept inside the range
			k = offset_within(4);
			for (int i = 0; i < 3; i++) begin
				p[i] = offset_within(1 << 18);
				d[i] = offset_within(1 << 12);
				p[i + 3] = p[i] + d[i];
				p[i + 6] = p[i] + k * d[i];
			end
		end else if (kind < 85) begin
			// coincident vertices
			case ($urandom_range(0, 3))
				0: for (int i = 0; i < 3; i++) p[i + 3] = p[i];
				1: for (int i = 0; i < 3; i++) p[i + 6] = p[i];
				2: for (int i = 0; i < 3; i++) p[i + 6] = p[i + 3];
				default: for (int i = 0; i < 3; i++) begin
					p[i + 3] = p[i];
					p[i + 6] = p[i];
				end
			endcase
		end else begin
			foreach (p[i])
				p[i] = corner_coord();
		end
		t = vertices(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
		return t;
	endfunction

	// Idle for gap cycles, then present the triangle and hold it until taken.
	// start stays high into the next transaction when the next gap is zero.
	task automatic drive_triangle(input tri_t t, input bit known, input area_t exp_area,
			input int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		ax <= t.ax;
		ay <= t.ay;
		az <= t.az;
		bx <= t.bx;
		by_coord <= t.by_coord;
		bz <= t.bz;
		cx <= t.cx;
		cy <= t.cy;
		cz <= t.cz;
		row_known = known;
		row_area = exp_area;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Hold off the sender until the pipeline has delivered everything.
	task automatic drain_pipeline();
		@(negedge clk);
		start <= 1'b0;
		while (pending_areas.size() != 0)
			@(negedge clk);
	endtask

	// Record each accepted transaction and check each result against the oldest
	// expectation. Sample at the rising edge: ports hold what the edge captures.
	always @(posedge clk) begin : result_check
		area_t oldest;
		if (arst_n) begin
			if (start && !busy)
				pending_areas.push_back(row_known ? row_area :
					twice_area_root(tri_t'{ax, ay, az, bx, by_coord, bz, cx, cy, cz}));
			if (done) begin
				if (pending_areas.size() == 0) begin
					$error("area: no result expected, actual %0d", area);
					failures++;
				end else begin
					oldest = pending_areas.pop_front();
					if (area !== oldest) begin
						$error("area: expected %0d, actual %0d", oldest, area);
						failures++;
					end
				end
			end
		end
	end

	// Count cycles in which neither side moves a transaction; give up at the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[triangle_area_3d] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		area_row_t directed_rows[$];
		int gap;
		row_known = 1'b0;
		row_area = '0;
		start = 1'b0;
		{ax, ay, az, bx, by_coord, bz, cx, cy, cz} = '0;
		arst_n = 1'b0;

		// Degenerate, unit right (each plane), full-range, small and bit-pattern triangles.
		directed_rows.push_back('{vertices(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
		directed_rows.push_back('{vertices(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
			C_MIN, C_MIN, C_MIN), 1'b1, '0});
		directed_rows.push_back('{vertices(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
			C_MAX, C_MAX, C_MAX), 1'b1, '0});
		directed_rows.push_back('{vertices(0, 0, 0, UNIT, 0, 0, 0, UNIT, 0), 1'b1,
			UNIT_RIGHT_AREA});
		directed_rows.push_back('{vertices(0, 0, 0, 0, UNIT, 0, 0, 0, UNIT), 1'b1,
			UNIT_RIGHT_AREA});
		directed_rows.push_back('{vertices(0, 0, 0, UNIT, 0, 0, 0, 0, UNIT), 1'b1,
			UNIT_RIGHT_AREA});
		directed_rows.push_back('{vertices(C_MIN, C_MIN, 0, C_MAX, C_MIN, 0, C_MIN, C_MAX, 0),
			1'b1, FULL_RIGHT_AREA});
		directed_rows.push_back('{vertices(0, 0, 0, 100, 200, 300, 200, 400, 600), 1'b1, '0});
		directed_rows.push_back('{vertices(-1000, -1000, -1000, 0, 0, 0, 1000, 1000, 1000),
			1'b1, '0});
		directed_rows.push_back('{vertices(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN,
			C_MIN, C_MAX, C_MAX), 1'b0, '0});
		directed_rows.push_back('{vertices(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
			C_MAX, C_MAX, C_MIN), 1'b0, '0});
		directed_rows.push_back('{vertices(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
			C_MIN, C_MIN, C_MAX), 1'b0, '0});
		directed_rows.push_back('{vertices(C_MIN, 0, C_MAX, C_MAX, C_MIN, 0, 0, C_MAX, C_MIN),
			1'b0, '0});
		directed_rows.push_back('{vertices(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
			C_MAX, C_MIN, C_MIN), 1'b0, '0});
		directed_rows.push_back('{vertices(-1, -1, -1, 1, 0, 0, 0, 1, 0), 1'b0, '0});
		directed_rows.push_back('{vertices(1, 1, 1, 2, 3, 5, 7, 11, 13), 1'b0, '0});
		directed_rows.push_back('{vertices('h55555, 'hAAAAA, 'h55555, 'hAAAAA, 'h55555,
			'hAAAAA, 'h33333, 'hCCCCC, 'h0F0F0), 1'b0, '0});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Walk the table back to back, then once more with random gaps.
		foreach (directed_rows[i])
			drive_triangle(directed_rows[i].verts, directed_rows[i].known,
				directed_rows[i].area, 0);
		foreach (directed_rows[i])
			drive_triangle(directed_rows[i].verts, directed_rows[i].known,
				directed_rows[i].area, $urandom_range(0, MAX_GAP));
		drain_pipeline();

		// Alternate stretches of back-to-back transactions with stretches of random gaps.
		for (int i = 0; i < RANDOM_TRIANGLES; i++) begin
			if (i == RANDOM_TRIANGLES / 3 || i == 2 * RANDOM_TRIANGLES / 3)
				drain_pipeline();
			gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
			drive_triangle(random_triangle(), 1'b0, '0, gap);
		end

		drain_pipeline();
		// Allow any stray result to surface before the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0 && pending_areas.size() == 0)
			$display("[triangle_area_3d] OK");
		else
			$display("[triangle_area_3d] ERROR");
		$finish;
	end

endmodule

FILE: triangle_area_3d.f
rtl/core/tri3d_pkg.sv
rtl/core/tri3d_sqrt.sv
rtl/core/triangle_area_3d.sv
verif/testbench.sv
